// ----- rtl/cfa_pkg.sv -----
// cfa_pkg: operation codes, field width and default word width for constant_fold_alu
// no dependencies
package cfa_pkg;

  localparam int WORD_WIDTH_DEFAULT = 32;
  localparam int FIELD_WIDTH = 32;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_NEG = 5'd8, OP_COMPL = 5'd9,
    OP_SHL = 5'd10, OP_SHR = 5'd11, OP_EQ = 5'd12, OP_NE = 5'd13, OP_LT = 5'd14,
    OP_GT = 5'd15, OP_LE = 5'd16, OP_GE = 5'd17, OP_SEL = 5'd18, OP_UNSUP = 5'd19
  } op_t;

endpackage

// ----- rtl/constant_fold_alu.sv -----
// constant_fold_alu: folds one constant integer operation, fully pipelined
// depends on cfa_pkg
//
//  channel | signals                                              | dir
//  request | valid ready command first_value second_value          | in
//          | third_value first_unsigned second_unsigned            |
//  result  | out_valid out_ready folded folded_value divide_error  | out
//
// one request per cycle unless the output stalls; the divider retires one quotient bit
// per stage (stage 0 decodes and prepares magnitudes, stages 1..W divide, one stage
// fixes signs and selects, one is the output)
// multiply is cut into half-word partial products in stage 0, summed in stage 1
// reset clears only the valid bits; payload registers hold stale data
// a stall freezes the whole pipe, bubbles included
module constant_fold_alu
  import cfa_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          ready,
  input  logic [4:0]                    command,
  input  logic signed [FIELD_WIDTH-1:0] first_value,
  input  logic signed [FIELD_WIDTH-1:0] second_value,
  input  logic signed [FIELD_WIDTH-1:0] third_value,
  input  logic                          first_unsigned,
  input  logic                          second_unsigned,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          folded,
  output logic signed [FIELD_WIDTH-1:0] folded_value,
  output logic                          divide_error
);

  localparam int W = WORD_WIDTH;
  localparam int NS = W + 2;  // stage 0, W divide stages, fix stage
  localparam int H = W / 2;   // low half of a word for the multiply split
  localparam int HW = W - H;  // high half

  // word from a 32-bit field, sign extended or cut
  function automatic logic [W-1:0] to_word(input logic [FIELD_WIDTH-1:0] f);
    logic [W+FIELD_WIDTH-1:0] e;
    e = {{W{f[FIELD_WIDTH-1]}}, f};
    return e[W-1:0];
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [W-1:0] w);
    logic [W+FIELD_WIDTH-1:0] e;
    e = {{FIELD_WIDTH{w[W-1]}}, w};
    return e[FIELD_WIDTH-1:0];
  endfunction

  // per stage payload
  typedef struct packed {
    logic [4:0]   cmd;
    logic         ok;
    logic         dz;
    logic [W-1:0] res;   // result for non-divide ops
    logic [W-1:0] rem;   // partial remainder
    logic [W-1:0] quo;   // dividend shifting into quotient
    logic [W-1:0] dvs;   // divisor magnitude
    logic         negq;
    logic         negr;
    logic [HW-1:0] mpc;  // cross partial products of the multiply
  } stg_t;

  stg_t        st [NS];
  logic [NS-1:0] vld;
  logic        ov;  // output register valid
  logic        adv;

  // pipe advances whenever the output slot is empty or being taken
  assign adv = !ov || out_ready;
  assign ready = adv;

  // ---------------- stage 0: decode and simple ops ----------------
  logic [W-1:0] a, b, c, ma, mb, shr_r;
  logic         uns, na, nb, sdiv, lt, gt;
  logic [H-1:0]   al, bl;
  logic [HW-1:0]  ah, bh, mpc;
  logic [2*H-1:0] mpl;
  stg_t         s0;

  always_comb begin
    a = to_word(first_value);
    b = to_word(second_value);
    c = to_word(third_value);
    uns = first_unsigned || second_unsigned;
    na = a[W-1];
    nb = b[W-1];
    sdiv = !uns;
    ma = (sdiv && na) ? -a : a;
    mb = (sdiv && nb) ? -b : b;
    lt = $signed(a) < $signed(b);
    gt = $signed(b) < $signed(a);
    al = a[H-1:0];
    bl = b[H-1:0];
    ah = a[W-1:H];
    bh = b[W-1:H];
    mpl = {{H{1'b0}}, al} * {{H{1'b0}}, bl};
    mpc = HW'(al) * bh + ah * HW'(bl);
    if (b >= W) shr_r = (!uns && na) ? '1 : '0;
    else if (!uns) shr_r = W'($signed(a) >>> b);
    else shr_r = a >> b;
    s0 = '0;
    s0.cmd = command;
    s0.ok = 1'b1;
    s0.rem = '0;
    s0.quo = ma;
    s0.dvs = mb;
    s0.negq = sdiv && (na != nb);
    s0.negr = sdiv && na;
    s0.mpc = mpc;
    unique case (command)
      OP_ADD:   s0.res = a + b;
      OP_SUB:   s0.res = a - b;
      OP_MUL:   s0.res = W'(mpl);
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          s0.ok = 1'b0;
          s0.dz = 1'b1;
        end
      end
      OP_AND:   s0.res = a & b;
      OP_OR:    s0.res = a | b;
      OP_XOR:   s0.res = a ^ b;
      OP_NEG:   s0.res = -a;
      OP_COMPL: s0.res = ~a;
      OP_SHL:   s0.res = (b >= W) ? '0 : (a << b);
      OP_SHR:   s0.res = shr_r;
      OP_EQ:    s0.res = W'(a == b);
      OP_NE:    s0.res = W'(a != b);
      OP_LT:    s0.res = W'(lt);
      OP_GT:    s0.res = W'(gt);
      OP_LE:    s0.res = W'(!gt);
      OP_GE:    s0.res = W'(!lt);
      OP_SEL:   s0.res = (a != '0) ? b : c;
      default:  s0.ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= valid;
    if (adv) st[0] <= s0;
  end

  // ---------------- divide stages: one restoring step each ----------------
  for (genvar i = 1; i <= W; i++) begin : g_div
    stg_t         nx;
    logic [W:0]   trial;
    logic [W:0]   sh;
    always_comb begin
      nx = st[i-1];
      sh = {st[i-1].rem, st[i-1].quo[W-1]};
      trial = sh - {1'b0, st[i-1].dvs};
      if (!trial[W]) begin
        nx.rem = trial[W-1:0];
        nx.quo = {st[i-1].quo[W-2:0], 1'b1};
      end else begin
        nx.rem = sh[W-1:0];
        nx.quo = {st[i-1].quo[W-2:0], 1'b0};
      end
      // first stage adds the shifted cross products of the multiply
      if (i == 1 && st[i-1].cmd == OP_MUL)
        nx.res = st[i-1].res + {st[i-1].mpc, {H{1'b0}}};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else if (adv) vld[i] <= vld[i-1];
      if (adv) st[i] <= nx;
    end
  end

  // ---------------- fix stage: signs and final select ----------------
  stg_t         fx;
  always_comb begin
    fx = st[W];
    if (st[W].cmd == OP_DIV) fx.res = st[W].negq ? -st[W].quo : st[W].quo;
    else if (st[W].cmd == OP_MOD) fx.res = st[W].negr ? -st[W].rem : st[W].rem;
    if (!st[W].ok) fx.res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[NS-1] <= 1'b0;
    else if (adv) vld[NS-1] <= vld[W];
    if (adv) st[NS-1] <= fx;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= vld[NS-1];
    if (adv) begin
      folded       <= st[NS-1].ok;
      folded_value <= to_field(st[NS-1].res);
      divide_error <= st[NS-1].dz;
    end
  end

  assign out_valid = ov;

endmodule

// ----- verif/tb_constant_fold_alu.sv -----
// tb_constant_fold_alu: self-checking testbench for constant_fold_alu
// depends on cfa_pkg and rtl/constant_fold_alu.sv; a directed table, then random requests
// checked against an in-bench fold predictor
module tb_constant_fold_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  localparam int W = WORD_WIDTH_DEFAULT;
  localparam int LATENCY = W + 3;
  localparam int N_RANDOM = 1600;

  // one folded answer as the block reports it
  typedef struct packed {
    logic        folded;
    logic [31:0] value;
    logic        dz;
  } fold_res_t;

  // one directed row; has_exp marks a hand-typed answer
  typedef struct {
    logic [4:0]  cmd;
    logic [31:0] a, b, c;
    logic        ua, ub;
    bit          has_exp;
    fold_res_t   exp;
  } dir_row_t;

  logic        clk, rst;
  logic        valid, ready;
  logic [4:0]  command;
  logic signed [31:0] first_value, second_value, third_value;
  logic        first_unsigned, second_unsigned;
  logic        out_valid, out_ready;
  logic        folded, divide_error;
  logic signed [31:0] folded_value;

  fold_res_t pending_folds[$];
  int        n_errors = 0;
  int        n_checked = 0;
  int        n_divzero = 0;
  bit        sending_done = 0;

  constant_fold_alu #(.WORD_WIDTH(W)) u_top (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .command(command), .first_value(first_value), .second_value(second_value),
    .third_value(third_value), .first_unsigned(first_unsigned),
    .second_unsigned(second_unsigned), .out_valid(out_valid), .out_ready(out_ready),
    .folded(folded), .folded_value(folded_value), .divide_error(divide_error)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // fold predictor at word width 32
  function automatic fold_res_t fold_predict(logic [4:0] cmd, logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic uns);
    fold_res_t   r;
    logic [31:0] ma, mb, q;
    r = '{folded: 1'b1, value: 32'd0, dz: 1'b0};
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (cmd)
      OP_ADD:   r.value = a + b;
      OP_SUB:   r.value = a - b;
      OP_MUL:   r.value = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          r.folded = 1'b0;
          r.dz = 1'b1;
        end else if (uns) begin
          r.value = (cmd == OP_DIV) ? a / b : a % b;
        end else if (cmd == OP_DIV) begin
          q = ma / mb;
          r.value = (a[31] != b[31]) ? -q : q;
        end else begin
          q = ma % mb;
          r.value = a[31] ? -q : q;
        end
      end
      OP_AND:   r.value = a & b;
      OP_OR:    r.value = a | b;
      OP_XOR:   r.value = a ^ b;
      OP_NEG:   r.value = -a;
      OP_COMPL: r.value = ~a;
      OP_SHL:   r.value = (b >= W) ? 32'd0 : a << b;
      OP_SHR: begin
        if (uns || !a[31]) r.value = (b >= W) ? 32'd0 : a >> b;
        else if (b >= W) r.value = 32'hffff_ffff;
        else r.value = $signed(a) >>> b;
      end
      OP_EQ:    r.value = {31'd0, a == b};
      OP_NE:    r.value = {31'd0, a != b};
      OP_LT:    r.value = {31'd0, $signed(a) < $signed(b)};
      OP_GT:    r.value = {31'd0, $signed(a) > $signed(b)};
      OP_LE:    r.value = {31'd0, $signed(a) <= $signed(b)};
      OP_GE:    r.value = {31'd0, $signed(a) >= $signed(b)};
      OP_SEL:   r.value = (a != 0) ? b : c;
      default:  r.folded = 1'b0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // drive one request and hold it until taken
  task automatic send_request(logic [4:0] cmd, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic ua, logic ub,
                              bit has_exp, fold_res_t exp);
    fold_res_t pred;
    int        gap;
    gap = $urandom_range(0, 6);
    if (($urandom_range(0, 3) == 0)) gap = 0;
    if (gap > 0) begin
      valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pred = fold_predict(cmd, a, b, c, ua | ub);
    if (has_exp && pred !== exp) begin
      // hand-typed row disagrees with predictor; trust the typed answer
      report_mismatch("table", {pred.folded, pred.dz, pred.value[29:0]},
                      {exp.folded, exp.dz, exp.value[29:0]});
      pred = exp;
    end
    valid <= 1;
    command <= cmd;
    first_value <= a;
    second_value <= b;
    third_value <= c;
    first_unsigned <= ua;
    second_unsigned <= ub;
    pending_folds.push_back(pred);
    @(posedge clk);
    while (!ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // result side: random stalls, check against the oldest expectation
  initial begin
    fold_res_t want;
    int        stall;
    out_ready = 0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_folds.size() == 0) begin
        report_mismatch("unexpected result", folded_value, 32'd0);
      end else begin
        want = pending_folds.pop_front();
        if (folded !== want.folded)
          report_mismatch("folded", {31'd0, folded}, {31'd0, want.folded});
        if (folded_value !== want.value) report_mismatch("folded_value", folded_value, want.value);
        if (divide_error !== want.dz)
          report_mismatch("divide_error", {31'd0, divide_error}, {31'd0, want.dz});
        if (want.dz) n_divzero++;
        n_checked++;
      end
    end
  end

  // request side
  initial begin
    dir_row_t  table_rows[$];
    fold_res_t none;
    logic [4:0] cmd;
    int         pick;
    none = '0;
    valid = 0;
    command = 0;
    first_value = 0;
    second_value = 0;
    third_value = 0;
    first_unsigned = 0;
    second_unsigned = 0;
    rst = 1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes, divide by zero, signed overflow, shift edges, unknown codes
    table_rows = '{
      '{OP_ADD, 32'h7fff_ffff, 32'd1, 32'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
      '{OP_SUB, 32'h8000_0000, 32'd1, 32'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 32'h7fff_ffff, 1'b0}},
      '{OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 1'b1, 1'b1, 1'b1,
        '{1'b1, 32'd1, 1'b0}},
      '{OP_DIV, 32'd5, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1, '{1'b0, 32'd0, 1'b1}},
      '{OP_MOD, 32'd5, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1, '{1'b0, 32'd0, 1'b1}},
      '{OP_DIV, 32'h8000_0000, 32'hffff_ffff, 32'd0, 1'b0, 1'b0, 1'b1,
        '{1'b1, 32'h8000_0000, 1'b0}},
      '{OP_MOD, 32'h8000_0000, 32'hffff_ffff, 32'd0, 1'b0, 1'b0, 1'b1,
        '{1'b1, 32'd0, 1'b0}},
      '{OP_DIV, 32'hffff_fff9, 32'd2, 32'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 32'hffff_fffd, 1'b0}},
      '{OP_MOD, 32'hffff_fff9, 32'd2, 32'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 32'hffff_ffff, 1'b0}},
      '{OP_DIV, 32'hffff_fff9, 32'd2, 32'd0, 1'b0, 1'b1, 1'b0, none},
      '{OP_AND, 32'hffff_0000, 32'h0ff0_0ff0, 32'd0, 1'b0, 1'b0, 1'b0, none},
      '{OP_OR,  32'hffff_0000, 32'h0ff0_0ff0, 32'd0, 1'b0, 1'b0, 1'b0, none},
      '{OP_XOR, 32'hffff_ffff, 32'h5555_5555, 32'd0, 1'b0, 1'b0, 1'b0, none},
      '{OP_NEG, 32'h8000_0000, 32'h1234, 32'h5, 1'b1, 1'b1, 1'b1,
        '{1'b1, 32'h8000_0000, 1'b0}},
      '{OP_COMPL, 32'd0, 32'hffff_ffff, 32'd0, 1'b0, 1'b0, 1'b1,
        '{1'b1, 32'hffff_ffff, 1'b0}},
      '{OP_SHL, 32'd1, 32'd31, 32'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
      '{OP_SHL, 32'd1, 32'd32, 32'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{OP_SHR, 32'h8000_0000, 32'hffff_ffff, 32'd0, 1'b0, 1'b0, 1'b1,
        '{1'b1, 32'hffff_ffff, 1'b0}},
      '{OP_SHR, 32'h8000_0000, 32'd31, 32'd0, 1'b1, 1'b0, 1'b1, '{1'b1, 32'd1, 1'b0}},
      '{OP_LT, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 1'b1, 1'b1, 1'b1, '{1'b1, 32'd1, 1'b0}},
      '{OP_GE, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 1'b1, 1'b1, 1'b1, '{1'b1, 32'd0, 1'b0}},
      '{OP_SEL, 32'h8000_0000, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b0, 1'b1,
        '{1'b1, 32'haaaa_aaaa, 1'b0}},
      '{OP_SEL, 32'd0, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b0, 1'b1,
        '{1'b1, 32'h5555_5555, 1'b0}},
      '{OP_UNSUP, 32'd1, 32'd2, 32'd3, 1'b0, 1'b0, 1'b1, '{1'b0, 32'd0, 1'b0}},
      '{5'd31, 32'hffff_ffff, 32'd0, 32'd3, 1'b1, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b0}}
    };
    foreach (table_rows[i])
      send_request(table_rows[i].cmd, table_rows[i].a, table_rows[i].b, table_rows[i].c,
                   table_rows[i].ua, table_rows[i].ub, table_rows[i].has_exp,
                   table_rows[i].exp);
    // all comparisons at equal operands
    for (int k = OP_EQ; k <= OP_GE; k++)
      send_request(k[4:0], 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b0, 1'b0, 1'b0, none);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 31);
      if (pick < 19) cmd = pick[4:0];
      else if (pick < 27) cmd = pick[0] ? OP_MOD : OP_DIV;
      else cmd = 5'($urandom_range(19, 31));
      send_request(cmd, rand_word(), ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word(),
                   $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, none);
    end
    valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done && pending_folds.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("checked %0d results over all codes, %0d of them divide by zero",
             n_checked, n_divzero);
    if (n_errors == 0 && pending_folds.size() == 0) begin
      $display("[constant_fold_alu] OK");
    end else begin
      $display("[constant_fold_alu] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", pending_folds.size());
    $display("[constant_fold_alu] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/cfa_pkg.sv
rtl/constant_fold_alu.sv
verif/tb_constant_fold_alu.sv
